@@ rtl/assert_macros.svh @@
// Assertion macros shared by the hash table RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/ohtab_pkg.sv @@
// Shared types and constants of the open-addressing hash table.
// No dependencies; imported by the controller, the datapath and the top level.
package ohtab_pkg;

   // Table geometry: slot count is a power of two so the home slot is a mask.
   localparam int SLOT_BITS   = 6;
   localparam int TABLE_SLOTS = 1 << SLOT_BITS;
   localparam int COUNT_BITS  = SLOT_BITS + 1;
   // A new key is refused once the count reaches three quarters of the slots.
   localparam logic [COUNT_BITS-1:0] LOAD_LIMIT = COUNT_BITS'((TABLE_SLOTS * 3) / 4);

   typedef enum logic [1:0] {
      FUNC_GET = 2'd0,
      FUNC_SET = 2'd1,
      FUNC_DEL = 2'd2
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] key_id;
      logic [31:0] key_hash;
      logic [63:0] new_value;
   } req_type;

   typedef struct packed {
      logic        flag;
      logic [63:0] value_out;
      logic        table_full;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;    // capture request, start probe at home slot
      logic skip;    // answer with all-zero result, no probe
      logic step;    // advance to next slot
      logic finish;  // commit and answer at current slot
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic trivial; // incoming beat needs no probe
      logic stop;    // probe ends at current slot
   } stat_type;

endpackage

@@ rtl/open_addressing_hash_table.sv @@
// Top level of the open-addressing hash table; depends on ohtab_pkg, ohtab_ctrl and ohtab_dp.
// A get or delete while the occupancy count is zero, or an unused func code, needs no probe and
// is answered in the cycle after it is taken, so such beats can be taken one a cycle. Other beats
// probe from the home slot (1..64 slots), one slot a cycle on the single memory read port.
// A new beat is taken in the cycle the previous answer is on the strobe; nothing stalls rsp.
// Reset: all slots empty at once (tags are flops), occupancy zero, no clearing pass.
module open_addressing_hash_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ohtab_pkg::req_type req_data,
   output logic               rsp_strobe,
   output ohtab_pkg::rsp_type rsp_data
);
   import ohtab_pkg::*;

   // Controller and datapath talk only through these two bundles.
   cmd_type  cmd;
   stat_type stat;

   // Sequence the probe: load at the home slot, advance a slot a cycle, finish on
   // a match, an empty slot or at the last slot of the table.
   ohtab_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Hold the tags, keys, values and occupancy; commit the update and drive the
   // registered answer for exactly one cycle.
   ohtab_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/ohtab_ctrl.sv @@
// Probe sequencer of the hash table: idle/probe state machine.
// Depends on ohtab_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ohtab_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ohtab_pkg::stat_type stat,
   output ohtab_pkg::cmd_type  cmd,
   output logic               busy
);
   import ohtab_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (stat.trivial) begin
                  cmd.skip = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (stat.stop) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in == ST_PROBE);
      end
   end

   assign busy = busy_ff;

   `ASSERT_CLK(a_finish_frees, clock, reset, cmd.finish |=> !busy, "busy after probe finished")
   `ASSERT_CLK(a_load_busy, clock, reset, cmd.load |=> busy, "not busy after load")
   `ASSERT_NEVER(a_idle_step, clock, reset, !busy && (cmd.step || cmd.finish), "probe cmd while idle")

endmodule

@@ rtl/ohtab_dp.sv @@
// Datapath of the hash table: slot tags, key/value memories, probe registers.
// Depends on ohtab_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ohtab_dp (
   input  logic                clock,
   input  logic                reset,
   input  ohtab_pkg::req_type  req_data,
   input  ohtab_pkg::cmd_type  cmd,
   output ohtab_pkg::stat_type stat,
   output logic                rsp_strobe,
   output ohtab_pkg::rsp_type  rsp_data
);
   import ohtab_pkg::*;

   // Key and value stores: one write port, one registered read port.
   logic [31:0] key_mem [TABLE_SLOTS];
   logic [63:0] val_mem [TABLE_SLOTS];
   logic [31:0] key_rd_ff;
   logic [63:0] val_rd_ff;

   // Slot tags as flops so reset empties the table at once.
   logic [TABLE_SLOTS-1:0] live_ff;
   logic [TABLE_SLOTS-1:0] tomb_ff;

   req_type                req_ff;
   logic [SLOT_BITS-1:0]   idx_ff, idx_in;
   logic [SLOT_BITS-1:0]   step_ff, step_in;
   logic                   tomb_seen_ff;
   logic [SLOT_BITS-1:0]   tomb_idx_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic                   cur_live, cur_tomb, hit, empty, last;
   logic [SLOT_BITS-1:0]   land_idx, wr_addr;
   logic                   land_ok, land_fresh;
   logic                   is_get, is_set, is_del;
   logic                   set_update, set_insert, del_hit, mem_we;
   logic                   in_func_ok;

   // Current slot view; memory data lines up with idx_ff.
   assign cur_live = live_ff[idx_ff];
   assign cur_tomb = tomb_ff[idx_ff];
   assign hit      = cur_live && (key_rd_ff == req_ff.key_id);
   assign empty    = !cur_live && !cur_tomb;
   assign last     = (step_ff == {SLOT_BITS{1'b1}});

   // Land on first tombstone seen, else the current slot.
   assign land_idx   = tomb_seen_ff ? tomb_idx_ff : idx_ff;
   assign land_ok    = empty || cur_tomb || tomb_seen_ff;
   assign land_fresh = empty && !tomb_seen_ff;

   assign is_get = (req_ff.func == FUNC_GET);
   assign is_set = (req_ff.func == FUNC_SET);
   assign is_del = (req_ff.func == FUNC_DEL);

   assign set_update = cmd.finish && is_set && hit;
   assign set_insert = cmd.finish && is_set && !hit && land_ok && (count_ff < LOAD_LIMIT);
   assign del_hit    = cmd.finish && is_del && hit;
   assign mem_we     = set_update || set_insert;
   assign wr_addr    = hit ? idx_ff : land_idx;

   assign in_func_ok = (req_data.func == FUNC_GET) || (req_data.func == FUNC_SET) ||
                       (req_data.func == FUNC_DEL);
   assign stat.trivial = !in_func_ok ||
                         ((req_data.func != FUNC_SET) && (count_ff == '0));
   assign stat.stop    = hit || empty || last;

   always_comb begin
      idx_in  = idx_ff;
      step_in = step_ff;
      if (cmd.load) begin
         idx_in  = req_data.key_hash[SLOT_BITS-1:0];
         step_in = '0;
      end else if (cmd.step) begin
         idx_in  = idx_ff + SLOT_BITS'(1);
         step_in = step_ff + SLOT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_addr] <= req_ff.key_id;
         val_mem[wr_addr] <= req_ff.new_value;
      end
      key_rd_ff <= key_mem[idx_in];
      val_rd_ff <= val_mem[idx_in];
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      step_ff <= step_in;
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.load) begin
         tomb_seen_ff <= 1'b0;
      end else if (cmd.step && cur_tomb && !tomb_seen_ff) begin
         tomb_seen_ff <= 1'b1;
         tomb_idx_ff  <= idx_ff;
      end
      if (cmd.finish) begin
         rsp_ff.flag       <= (is_get && hit) || set_insert || del_hit;
         rsp_ff.value_out  <= (is_get && hit) ? val_rd_ff : 64'd0;
         rsp_ff.table_full <= is_set && !hit && !set_insert;
      end else if (cmd.skip) begin
         rsp_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         tomb_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish || cmd.skip;
         if (set_insert) begin
            live_ff[land_idx] <= 1'b1;
            tomb_ff[land_idx] <= 1'b0;
            if (land_fresh) begin
               count_ff <= count_ff + COUNT_BITS'(1);
            end
         end
         if (del_hit) begin
            live_ff[idx_ff] <= 1'b0;
            tomb_ff[idx_ff] <= 1'b1;
         end
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `ASSERT_NEVER(a_count_cap, clock, reset, count_ff > LOAD_LIMIT, "count above load limit")
   `ASSERT_NEVER(a_tag_excl, clock, reset, (live_ff & tomb_ff) != '0, "slot live and tombstone")
   `ASSERT_NEVER(a_full_flag, clock, reset, rsp_valid_ff && rsp_ff.table_full && rsp_ff.flag, "full with flag")

endmodule

@@ sim/open_addressing_hash_table_tb.sv @@
// Self-checking testbench for open_addressing_hash_table: directed and random get/set/delete beats.
// Depends on ohtab_pkg (request/response structs, func codes, table geometry) and the RTL top.
// A shadow copy of the slot array predicts every answer; a monitor compares each strobed answer.
module open_addressing_hash_table_tb;
   import ohtab_pkg::*;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 11;
   localparam int MAX_GAP        = 18;
   localparam int RANDOM_BEATS   = 1600;
   localparam int POOL_SIZE      = 64;
   // Keys whose hashes crowd two small windows, one of them across the wrap point.
   localparam int HOT_KEYS       = 24;
   localparam int HOT_PHASE      = 600;
   // Longest answer: all 64 slots probed; leave some slack.
   localparam int TAIL_CYCLES    = 2 * TABLE_SLOTS + 16;
   localparam int TIMEOUT_CYCLES = 2_000_000;

   // Unused func code; the block must answer all zeros and change nothing.
   localparam func_type FUNC_UNUSED = func_type'(2'b11);

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_LIVE  = 2'd1,
      SLOT_TOMB  = 2'd2
   } slot_state_type;

   typedef enum int {
      GAP_NONE,
      GAP_SPARSE,
      GAP_FULL
   } gap_mode_type;

   // Shadow of the table: slot tags, keys, values and the fill count, plus the answers
   // still owed by the block in the order the beats were taken.
   class table_shadow_type;
      slot_state_type slot_tag [TABLE_SLOTS];
      logic [31:0] slot_key [TABLE_SLOTS];
      logic [63:0] slot_val [TABLE_SLOTS];
      int          fill_count;
      rsp_type     answers_due [$];
      int          errors;

      function new();
         foreach (slot_tag[i]) slot_tag[i] = SLOT_EMPTY;
         fill_count = 0;
         errors     = 0;
      endfunction

      task report_mismatch(input string what);
         errors++;
         $display("%0t: mismatch: %s", $time, what);
      endtask

      // Walk from the home slot; stop on a live match or an empty slot, remember the
      // first tombstone, give up after one full lap.
      function void probe(input logic [31:0] key_id, input logic [31:0] key_hash,
                          output int hit, output int land);
         int idx;
         int first_tomb;
         int n;
         idx        = int'(key_hash % TABLE_SLOTS);
         first_tomb = -1;
         hit        = -1;
         land       = -1;
         for (n = 0; n < TABLE_SLOTS; n++) begin
            case (slot_tag[idx])
               SLOT_LIVE: begin
                  if (slot_key[idx] == key_id) begin
                     hit  = idx;
                     land = idx;
                     return;
                  end
               end
               SLOT_TOMB: begin
                  if (first_tomb < 0) first_tomb = idx;
               end
               default: begin
                  land = (first_tomb >= 0) ? first_tomb : idx;
                  return;
               end
            endcase
            idx = (idx + 1) % TABLE_SLOTS;
         end
         land = first_tomb;
      endfunction

      // Apply one taken beat to the shadow and queue the answer it must produce.
      function void take_request(input req_type beat);
         rsp_type ans;
         int      hit;
         int      land;
         ans = '0;
         case (beat.func)
            FUNC_GET: begin
               if (fill_count != 0) begin
                  probe(beat.key_id, beat.key_hash, hit, land);
                  if (hit >= 0) begin
                     ans.flag      = 1'b1;
                     ans.value_out = slot_val[hit];
                  end
               end
            end
            FUNC_SET: begin
               probe(beat.key_id, beat.key_hash, hit, land);
               if (hit >= 0) begin
                  slot_val[hit] = beat.new_value;
               end else if ((fill_count + 1) * 4 > TABLE_SLOTS * 3 || land < 0) begin
                  ans.table_full = 1'b1;
               end else begin
                  if (slot_tag[land] == SLOT_EMPTY) fill_count++;
                  slot_tag[land] = SLOT_LIVE;
                  slot_key[land] = beat.key_id;
                  slot_val[land] = beat.new_value;
                  ans.flag       = 1'b1;
               end
            end
            FUNC_DEL: begin
               if (fill_count != 0) begin
                  probe(beat.key_id, beat.key_hash, hit, land);
                  if (hit >= 0) begin
                     slot_tag[hit] = SLOT_TOMB;
                     ans.flag      = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         answers_due.push_back(ans);
      endfunction

      // Compare one strobed answer with the oldest one owed.
      task match_answer(input rsp_type got);
         rsp_type want;
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("answer with none owed: flag=%0b value=%h full=%0b",
                                      got.flag, got.value_out, got.table_full));
            return;
         end
         want = answers_due.pop_front();
         if (got.flag !== want.flag)
            report_mismatch($sformatf("flag %0b, want %0b", got.flag, want.flag));
         if (got.value_out !== want.value_out)
            report_mismatch($sformatf("value_out %h, want %h", got.value_out, want.value_out));
         if (got.table_full !== want.table_full)
            report_mismatch($sformatf("table_full %0b, want %0b",
                                      got.table_full, want.table_full));
      endtask
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   table_shadow_type shadow = new();
   // Beats taken but not yet answered; updated at the edge so drivers read it race-free.
   int          outstanding = 0;
   gap_mode_type gap_mode   = GAP_SPARSE;

   logic [31:0] pool_key  [POOL_SIZE];
   logic [31:0] pool_hash [POOL_SIZE];

   open_addressing_hash_table dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Monitor: sample both channels at the edge that ends the cycle. Check the answer first;
   // a beat taken at the same edge is owed a later answer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) shadow.match_answer(rsp_data);
         if (start && !busy) shadow.take_request(req_data);
         outstanding <= outstanding + ((start && !busy) ? 1 : 0) - (rsp_strobe ? 1 : 0);
      end
   end

   function automatic int draw_gap();
      case (gap_mode)
         GAP_NONE:   return 0;
         GAP_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
         default:    return $urandom_range(0, MAX_GAP);
      endcase
   endfunction

   function automatic req_type make_beat(input func_type f, input logic [31:0] key_id,
                                         input logic [31:0] key_hash,
                                         input logic [63:0] value);
      req_type b;
      b.func      = f;
      b.key_id    = key_id;
      b.key_hash  = key_hash;
      b.new_value = value;
      return b;
   endfunction

   // Mostly well-formed traffic on the key pool (each key keeps its own hash); the rest
   // is noise: unused func codes, foreign keys, pool keys under a wrong hash.
   function automatic req_type random_beat(input int pool_used);
      req_type b;
      int      pick;
      int      roll;
      pick        = $urandom_range(0, pool_used - 1);
      roll        = $urandom_range(0, 99);
      b.key_id    = pool_key[pick];
      b.key_hash  = pool_hash[pick];
      b.new_value = {$urandom(), $urandom()};
      if ($urandom_range(0, 15) == 0) b.new_value = $urandom_range(0, 1) ? '1 : '0;
      if (roll < 40) begin
         b.func = FUNC_SET;
      end else if (roll < 72) begin
         b.func = FUNC_GET;
      end else if (roll < 92) begin
         b.func = FUNC_DEL;
      end else begin
         b.func = func_type'(2'($urandom_range(0, 3)));
         if (roll < 96) begin
            b.key_hash = $urandom();
         end else if (roll < 98) begin
            b.key_id = $urandom();
         end else begin
            b.key_id   = $urandom();
            b.key_hash = $urandom();
         end
      end
      return b;
   endfunction

   // Call right after a rising edge. Idle for the drawn gap, then hold start until the
   // beat is taken. Start stays high on return so a gap-free next beat follows at once.
   task automatic send_beat(input req_type beat, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and hold off until every owed answer has come back.
   task automatic wait_for_answers();
      start <= 1'b0;
      do @(posedge clock); while (outstanding > 0);
   endtask

   initial begin
      int i;
      int j;

      for (j = 0; j < POOL_SIZE; j++) begin
         pool_key[j]  = $urandom();
         pool_hash[j] = $urandom();
         if (j < HOT_KEYS) begin
            // Even keys land on slots 60..3 across the wrap, odd keys on 20..25.
            pool_hash[j][SLOT_BITS-1:0] = (j % 2 == 0) ?
               SLOT_BITS'(TABLE_SLOTS - 4 + $urandom_range(0, 7)) :
               SLOT_BITS'(20 + $urandom_range(0, 5));
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, unused code, key 0, extreme keys and values, wrap-around
      // probe, update of a present key, delete and repeat delete, tombstone reuse.
      gap_mode = GAP_SPARSE;
      send_beat(make_beat(FUNC_GET, 32'd1, 32'd5, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_DEL, 32'd1, 32'd5, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_UNUSED, '1, '1, '1), draw_gap());
      send_beat(make_beat(FUNC_SET, 32'd0, 32'd0, '1), draw_gap());
      send_beat(make_beat(FUNC_GET, 32'd0, 32'd0, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_SET, '1, '1, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_SET, 32'h1234_5678, 32'h0000_003F, {32{2'b01}}),
                draw_gap());
      send_beat(make_beat(FUNC_GET, 32'h1234_5678, 32'h0000_003F, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_SET, 32'd0, 32'd0, 64'h0123_4567_89AB_CDEF), draw_gap());
      send_beat(make_beat(FUNC_GET, 32'd0, 32'd0, '1), draw_gap());
      send_beat(make_beat(FUNC_DEL, '1, '1, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_DEL, '1, '1, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_GET, 32'h1234_5678, 32'h0000_003F, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_SET, 32'h8000_0000, 32'h8000_003F, {32{2'b10}}),
                draw_gap());
      send_beat(make_beat(FUNC_GET, 32'h8000_0000, 32'h8000_003F, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_GET, 32'd7, 32'h0000_0010, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_DEL, 32'd0, 32'd0, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_GET, 32'h1234_5678, 32'h0000_003F, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_SET, 32'd0, 32'd0, 64'd1), draw_gap());
      send_beat(make_beat(FUNC_UNUSED, 32'd0, 32'd0, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_DEL, 32'h1234_5678, 32'h0000_003F, 64'd0), draw_gap());
      send_beat(make_beat(FUNC_GET, 32'h1234_5678, 32'h0000_003F, 64'd0), draw_gap());
      wait_for_answers();

      // Random: a small crowded pool first so tombstones pile up below the load limit,
      // then the full pool drives the count to the limit and keeps refusing new keys.
      for (i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 50 == 0) gap_mode = gap_mode_type'($urandom_range(0, 2));
         if (i == HOT_PHASE || i == 2 * HOT_PHASE || $urandom_range(0, 299) == 0)
            wait_for_answers();
         send_beat(random_beat(i < HOT_PHASE ? HOT_KEYS : POOL_SIZE), draw_gap());
      end
      start <= 1'b0;

      // Drain, then watch a while longer for stray strobes.
      do @(posedge clock); while (outstanding > 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.answers_due.size() != 0)
         shadow.report_mismatch($sformatf("%0d answers never came",
                                          shadow.answers_due.size()));

      if (shadow.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("TEST FAILED");
      $finish;
   end

endmodule
